FILE: rtl/stlt_pkg.sv
package stlt_pkg;

  localparam int unsigned ElapsedW = 26;
  localparam int unsigned LevelW = 8;
  localparam int unsigned StairW = 16;
  localparam int unsigned PctW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned TicksPerSecondDefault = 1000;
  localparam int unsigned StairTimeReset = 60;

  localparam logic [LevelW-1:0] LevelOn = 8'hFE;
  localparam logic [LevelW-1:0] LevelOff = 8'h00;
  localparam logic [LevelW-1:0] LevelMax = 8'hFF;

  // pct * 254 / 100 is taken as (pct * 254 * 5243) >> 19. The reciprocal error stays
  // below 1/100 of one step for every 7-bit percent, so the truncation is exact.
  localparam int unsigned PctProdW = 28;
  localparam int unsigned PctLevelShift = 19;
  localparam logic [PctProdW-1:0] PctLevelMul = 28'd1331722;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_DIM    = 2'd2,
    CMD_LOCK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OFF   = 2'd1,
    ACT_ON    = 2'd2,
    ACT_LEVEL = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STAIR_TIME    = 3'd0,
    CFG_RETRIGGER     = 3'd1,
    CFG_MANUAL_OFF    = 3'd2,
    CFG_LOCK_ACTION   = 3'd3,
    CFG_LOCK_LEVEL    = 3'd4,
    CFG_UNLOCK_ACTION = 3'd5,
    CFG_UNLOCK_LEVEL  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              retrigger_enable;
    logic              manual_off_enable;
    action_e           lock_action;
    logic [LevelW-1:0] lock_level;
    action_e           unlock_action;
    logic [LevelW-1:0] unlock_level;
  } cfg_t;

  typedef struct packed {
    cmd_e              command;
    logic              switch_value;
    logic [LevelW-1:0] dim_value;
    logic              lock_value;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] arc_level;
  } result_t;

  function automatic logic [LevelW-1:0] pct_to_level(input logic [PctW-1:0] pct);
    logic [PctProdW-1:0] prod;
    logic [PctProdW-PctLevelShift-1:0] lvl;
    prod = PctProdW'(pct) * PctLevelMul;
    lvl = prod[PctProdW-1:PctLevelShift];
    if (lvl > (PctProdW-PctLevelShift)'(LevelMax)) begin
      return LevelMax;
    end
    return lvl[LevelW-1:0];
  endfunction

endpackage

FILE: rtl/stlt_cfg.sv
module stlt_cfg #(
  parameter int unsigned TicksPerSecond = stlt_pkg::TicksPerSecondDefault,
  parameter int unsigned LimitW = stlt_pkg::StairW + $clog2(TicksPerSecond + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stlt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [stlt_pkg::CfgDataW-1:0]  cfg_data_i,
  output stlt_pkg::cfg_t                 cfg_o,
  output logic [LimitW-1:0]              limit_o
);

  // The timeout threshold is kept in ticks, so the multiply happens once per write.
  localparam logic [LimitW-1:0] LimitReset =
      LimitW'(stlt_pkg::StairTimeReset) * LimitW'(TicksPerSecond);

  stlt_pkg::cfg_t    cfg_q, cfg_d;
  logic [LimitW-1:0] limit_q, limit_d;

  always_comb begin
    cfg_d = cfg_q;
    limit_d = limit_q;
    if (cfg_we_i) begin
      unique case (stlt_pkg::cfg_idx_e'(cfg_index_i))
        stlt_pkg::CFG_STAIR_TIME: begin
          limit_d = LimitW'(cfg_data_i[stlt_pkg::StairW-1:0]) * LimitW'(TicksPerSecond);
        end
        stlt_pkg::CFG_RETRIGGER:     cfg_d.retrigger_enable = cfg_data_i[0];
        stlt_pkg::CFG_MANUAL_OFF:    cfg_d.manual_off_enable = cfg_data_i[0];
        stlt_pkg::CFG_LOCK_ACTION:   cfg_d.lock_action = stlt_pkg::action_e'(cfg_data_i[1:0]);
        stlt_pkg::CFG_LOCK_LEVEL: begin
          cfg_d.lock_level = stlt_pkg::pct_to_level(cfg_data_i[stlt_pkg::PctW-1:0]);
        end
        stlt_pkg::CFG_UNLOCK_ACTION: begin
          cfg_d.unlock_action = stlt_pkg::action_e'(cfg_data_i[1:0]);
        end
        stlt_pkg::CFG_UNLOCK_LEVEL: begin
          cfg_d.unlock_level = stlt_pkg::pct_to_level(cfg_data_i[stlt_pkg::PctW-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retrigger_enable <= 1'b0;
      cfg_q.manual_off_enable <= 1'b0;
      cfg_q.lock_action <= stlt_pkg::ACT_NONE;
      cfg_q.lock_level <= stlt_pkg::LevelOff;
      cfg_q.unlock_action <= stlt_pkg::ACT_NONE;
      cfg_q.unlock_level <= stlt_pkg::LevelOff;
      limit_q <= LimitReset;
    end else begin
      cfg_q <= cfg_d;
      limit_q <= limit_d;
    end
  end

  assign cfg_o = cfg_q;
  assign limit_o = limit_q;

endmodule

FILE: rtl/stlt_ctrl.sv
module stlt_ctrl #(
  parameter int unsigned LimitW = stlt_pkg::StairW + 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              process_i,
  input  stlt_pkg::item_t   item_i,
  input  stlt_pkg::cfg_t    cfg_i,
  input  logic [LimitW-1:0] limit_i,
  output stlt_pkg::result_t result_o
);

  localparam int unsigned ElapsedW = stlt_pkg::ElapsedW;
  localparam int unsigned CmpW = (LimitW > ElapsedW) ? LimitW : ElapsedW;
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  logic                light_on_q, light_on_d;
  logic                locked_q, locked_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [ElapsedW-1:0] elapsed_inc;
  stlt_pkg::action_e   action;
  logic [stlt_pkg::LevelW-1:0] fixed_level;

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign action = item_i.lock_value ? cfg_i.lock_action : cfg_i.unlock_action;
  assign fixed_level = item_i.lock_value ? cfg_i.lock_level : cfg_i.unlock_level;

  always_comb begin
    light_on_d = light_on_q;
    locked_d = locked_q;
    elapsed_d = elapsed_q;
    result_o.valid = 1'b0;
    result_o.arc_level = stlt_pkg::LevelOff;
    unique case (item_i.command)
      stlt_pkg::CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (light_on_q && (CmpW'(elapsed_inc) > CmpW'(limit_i))) begin
          light_on_d = 1'b0;
          result_o.valid = 1'b1;
        end
      end
      stlt_pkg::CMD_SWITCH: begin
        if (!locked_q) begin
          if (item_i.switch_value) begin
            if (light_on_q) begin
              if (cfg_i.retrigger_enable) begin
                elapsed_d = '0;
              end
            end else begin
              light_on_d = 1'b1;
              elapsed_d = '0;
              result_o.valid = 1'b1;
              result_o.arc_level = stlt_pkg::LevelOn;
            end
          end else if (cfg_i.manual_off_enable) begin
            light_on_d = 1'b0;
            result_o.valid = 1'b1;
          end
        end
      end
      stlt_pkg::CMD_DIM: begin
        if (!locked_q) begin
          result_o.valid = 1'b1;
          result_o.arc_level = item_i.dim_value;
        end
      end
      stlt_pkg::CMD_LOCK: begin
        if (item_i.lock_value != locked_q) begin
          locked_d = item_i.lock_value;
          unique case (action)
            stlt_pkg::ACT_NONE: ;
            stlt_pkg::ACT_OFF:  result_o.valid = 1'b1;
            stlt_pkg::ACT_ON: begin
              result_o.valid = 1'b1;
              result_o.arc_level = stlt_pkg::LevelOn;
            end
            stlt_pkg::ACT_LEVEL: begin
              result_o.valid = 1'b1;
              result_o.arc_level = fixed_level;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_on_q <= 1'b0;
      locked_q <= 1'b0;
      elapsed_q <= '0;
    end else if (process_i) begin
      light_on_q <= light_on_d;
      locked_q <= locked_d;
      elapsed_q <= elapsed_d;
    end
  end

  a_lock_only_on_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(process_i && item_i.command == stlt_pkg::CMD_LOCK) |=> $stable(locked_q))
    else $error("lock state changed without a lock event");

  a_tick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
      process_i && item_i.command == stlt_pkg::CMD_TICK |=> elapsed_q >= $past(elapsed_q))
    else $error("elapsed counter went backwards on a tick");

  a_timeout_needs_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
      process_i && item_i.command == stlt_pkg::CMD_TICK && result_o.valid
      |=> !light_on_q && $past(light_on_q))
    else $error("timeout reported while the lamp was dark");

  a_switch_on_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
      process_i && item_i.command == stlt_pkg::CMD_SWITCH && result_o.valid
      && result_o.arc_level == stlt_pkg::LevelOn |=> light_on_q && elapsed_q == '0)
    else $error("switch-on result without lighting the lamp");

endmodule

FILE: rtl/staircase_light_timer.sv
// Staircase light channel. Each transfer on the input carries one event: a millisecond
// tick, a switch event, an absolute dim value or a lock change; each event yields zero or
// one lamp arc level on the output. The block takes one event per clock cycle while the
// output is not stalled; an event is registered in the input register on transfer and,
// once the result register is free, its arc level, if any, is written to the result
// register, from which it is offered on the output. A result that waits on a stalled
// output holds the event behind it in the input register, and the input then stalls. The
// stair time is stored as a tick threshold (stair_time_s times
// TicksPerSecond), and the lock and unlock percentages are stored as arc levels, both
// converted when the register is written, so configuration must be written only while no
// event is in flight. Register index 0 is the stair time in seconds, 1 retrigger enable,
// 2 manual-off enable, 3 lock action, 4 lock percent, 5 unlock action, 6 unlock percent;
// index 7 is ignored.
module staircase_light_timer #(
  parameter int unsigned TicksPerSecond = stlt_pkg::TicksPerSecondDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stlt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [stlt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic                          switch_value_i,
  input  logic [stlt_pkg::LevelW-1:0]   dim_value_i,
  input  logic                          lock_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [stlt_pkg::LevelW-1:0]   arc_level_o
);

  // Wide enough for 65535 seconds at the configured tick rate.
  localparam int unsigned LimitW = stlt_pkg::StairW + $clog2(TicksPerSecond + 1);

  stlt_pkg::cfg_t    cfg;
  logic [LimitW-1:0] limit;

  // Input register: one event waiting to be processed.
  logic              in_valid_q;
  stlt_pkg::item_t   item_q;

  // Result register, facing the output channel.
  logic                        out_valid_q;
  logic [stlt_pkg::LevelW-1:0] arc_level_q;

  stlt_pkg::result_t result;
  logic              out_free;
  logic              advance;
  logic              in_ready;

  // The result register can be loaded when it is empty or its content is leaving now.
  assign out_free = !out_valid_q || !out_stall_i;
  // The event in the input register is processed, and the channel state updated, exactly
  // when its result, or the lack of one, can be written to the result register.
  assign advance = in_valid_q && out_free;
  assign in_ready = !in_valid_q || advance;
  assign in_stall_o = !in_ready;

  stlt_cfg #(
    .TicksPerSecond(TicksPerSecond),
    .LimitW        (LimitW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .limit_o    (limit)
  );

  stlt_ctrl #(
    .LimitW(LimitW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .process_i(advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .limit_i  (limit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  // The payload needs no reset; it is only looked at while in_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      item_q.command <= stlt_pkg::cmd_e'(command_i);
      item_q.switch_value <= switch_value_i;
      item_q.dim_value <= dim_value_i;
      item_q.lock_value <= lock_value_i;
    end
  end

  // An event that yields no arc level simply leaves the result register empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      arc_level_q <= result.arc_level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign arc_level_o = arc_level_q;

endmodule
